>>> rtl/core/ekest_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder kinematics estimator package
// Shared widths, wrap correction constants and the divider control struct.
// ----------------------------------------------------------------------------
package ekest_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int TIME_WIDTH  = 32;
   localparam int INDEX_WIDTH = 32;
   localparam int DIFF_WIDTH  = COUNT_WIDTH + 1;

   // Counter wrap correction thresholds and offsets.
   localparam logic signed [DIFF_WIDTH-1:0] WRAP_LIMIT     = 17'sd16383;
   localparam logic signed [DIFF_WIDTH-1:0] WRAP_LIMIT_NEG = -17'sd16383;
   localparam logic signed [DIFF_WIDTH-1:0] WRAP_DOWN      = 17'sd32767;
   localparam logic signed [DIFF_WIDTH-1:0] WRAP_UP        = 17'sd32768;

   typedef struct packed {
      logic start;
      logic neg;
   } div_ctrl_type;

endpackage

>>> rtl/core/ekest_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder kinematics estimator channels
// Valid/ready channels for samples in and kinematic results out.
// ----------------------------------------------------------------------------
interface ekest_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [ekest_pkg::COUNT_WIDTH-1:0] count_value;
   logic        [ekest_pkg::TIME_WIDTH-1:0]  time_us;

   modport source (output valid, output count_value, output time_us, input ready);
   modport sink   (input valid, input count_value, input time_us, output ready);
endinterface

interface ekest_rsp_if #(parameter int RES_WIDTH = 48);
   logic                                  valid;
   logic                                  ready;
   logic signed [RES_WIDTH-1:0]           speed;
   logic signed [RES_WIDTH-1:0]           accel;
   logic signed [RES_WIDTH-1:0]           jerk;
   logic        [ekest_pkg::TIME_WIDTH-1:0]  elapsed_us;
   logic                                  wrapped;
   logic                                  zero_interval;
   logic        [ekest_pkg::INDEX_WIDTH-1:0] sample_index;

   modport source (output valid, output speed, output accel, output jerk,
                   output elapsed_us, output wrapped, output zero_interval,
                   output sample_index, input ready);
   modport sink   (input valid, input speed, input accel, input jerk,
                   input elapsed_us, input wrapped, input zero_interval,
                   input sample_index, output ready);
endinterface

>>> rtl/core/ekest_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial saturating divider
// Restoring division of a magnitude by a 32-bit interval, one quotient bit
// per cycle, then signed saturation to the result width.
// ----------------------------------------------------------------------------
module ekest_div #(
   parameter int DIV_WIDTH = 49,
   parameter int RES_WIDTH = 48
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ekest_pkg::div_ctrl_type           ctrl,
   input  logic [DIV_WIDTH-1:0]              mag,
   input  logic [ekest_pkg::TIME_WIDTH-1:0]  divisor,
   output logic                              done,
   output logic [RES_WIDTH-1:0]              result
);

   localparam int CNT_WIDTH = $clog2(DIV_WIDTH);
   localparam int TW        = ekest_pkg::TIME_WIDTH;

   logic                 run_ff, run_in;
   logic                 fin_ff, fin_in;
   logic                 done_ff, done_in;
   logic                 neg_ff, neg_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [TW-1:0]        rem_ff, rem_in;
   logic [DIV_WIDTH-1:0] quo_ff, quo_in;
   logic [RES_WIDTH-1:0] res_ff, res_in;

   logic [TW:0]          rem_shift;
   logic [TW:0]          rem_trial;
   logic                 fits;
   logic                 sat_pos;
   logic                 sat_neg;
   logic [RES_WIDTH-1:0] quo_low;

   assign rem_shift = {rem_ff, quo_ff[DIV_WIDTH-1]};
   assign fits      = rem_shift >= {1'b0, divisor};
   assign rem_trial = rem_shift - {1'b0, divisor};
   assign quo_low   = quo_ff[RES_WIDTH-1:0];

   // Positive quotients clip at 2^(W-1)-1, negative ones at -2^(W-1).
   assign sat_pos = |quo_ff[DIV_WIDTH-1:RES_WIDTH-1];
   assign sat_neg = (|quo_ff[DIV_WIDTH-1:RES_WIDTH])
                    || (quo_ff[RES_WIDTH-1] && (|quo_ff[RES_WIDTH-2:0]));

   always_comb begin
      run_in  = run_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      res_in  = res_ff;
      if (ctrl.start) begin
         run_in = 1'b1;
         neg_in = ctrl.neg;
         cnt_in = CNT_WIDTH'(DIV_WIDTH - 1);
         rem_in = '0;
         quo_in = mag;
      end else if (run_ff) begin
         rem_in = fits ? rem_trial[TW-1:0] : rem_shift[TW-1:0];
         quo_in = {quo_ff[DIV_WIDTH-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end
      end else if (fin_ff) begin
         done_in = 1'b1;
         if (neg_ff) begin
            res_in = sat_neg ? {1'b1, {(RES_WIDTH-1){1'b0}}} : (~quo_low + 1'b1);
         end else begin
            res_in = sat_pos ? {1'b0, {(RES_WIDTH-1){1'b1}}} : quo_low;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      res_ff <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |-> !run_ff && !fin_ff)
      else $error("divider started while busy");

   a_last_bit_finishes: assert property (@(posedge clock) disable iff (reset)
      run_ff && !ctrl.start && cnt_ff == '0 |=> fin_ff && !run_ff)
      else $error("divider did not finish after last bit");

   a_fin_gives_done: assert property (@(posedge clock) disable iff (reset)
      fin_ff && !ctrl.start |=> done_ff)
      else $error("divider finish without done");

endmodule

>>> rtl/core/encoder_kinematics_estimator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder kinematics estimator
// Speed, acceleration and jerk from quadrature counter samples by
// successive finite differences divided by the elapsed microseconds.
// ----------------------------------------------------------------------------
// Sequencing: three bit-serial divisions, for speed, acceleration and jerk,
//    share one restoring divider at one quotient bit per cycle.
// Flow: a new sample is taken only in the idle state, once the result of the
//    last one has moved into the output register; a sample with zero elapsed
//    time skips the divider and goes straight to the output step.
// Reset: synchronous, active high; clears the history to zero and drops valid.
// ----------------------------------------------------------------------------
module encoder_kinematics_estimator #(
   parameter int FRAC_BITS    = 24,
   parameter int RESULT_WIDTH = 48
) (
   input logic         clock,
   input logic         reset,
   ekest_req_if.sink   req_chan,
   ekest_rsp_if.source rsp_chan
);

   // The dividend must hold a shifted count difference and the magnitude of
   // a difference of two saturated results.
   localparam int DIV_WIDTH = (RESULT_WIDTH + 1 > FRAC_BITS + 16)
                              ? RESULT_WIDTH + 1 : FRAC_BITS + 16;
   localparam int RW  = RESULT_WIDTH;
   localparam int DW  = ekest_pkg::DIFF_WIDTH;
   localparam int CW  = ekest_pkg::COUNT_WIDTH;
   localparam int TW  = ekest_pkg::TIME_WIDTH;
   localparam int IW  = ekest_pkg::INDEX_WIDTH;

   // Sequencer states.
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_WRAP  = 3'd1;
   localparam logic [2:0] S_DIV_S = 3'd2;
   localparam logic [2:0] S_ABS_A = 3'd3;
   localparam logic [2:0] S_DIV_A = 3'd4;
   localparam logic [2:0] S_ABS_J = 3'd5;
   localparam logic [2:0] S_DIV_J = 3'd6;
   localparam logic [2:0] S_OUT   = 3'd7;

   logic [2:0]           state_ff, state_in;

   // History carried from one sample to the next.
   logic [CW-1:0]        prev_count_ff, prev_count_in;
   logic [TW-1:0]        prev_time_ff, prev_time_in;
   logic [RW-1:0]        prev_speed_ff, prev_speed_in;
   logic [RW-1:0]        prev_accel_ff, prev_accel_in;
   logic [IW-1:0]        samples_ff, samples_in;

   // Working registers of the sample in flight.
   logic signed [DW-1:0] diff_ff, diff_in;
   logic [TW-1:0]        dt_ff, dt_in;
   logic [IW-1:0]        index_ff, index_in;
   logic                 wrapped_ff, wrapped_in;
   logic [RW-1:0]        speed_ff, speed_in;
   logic [RW-1:0]        accel_ff, accel_in;
   logic [RW-1:0]        jerk_ff, jerk_in;
   logic signed [RW:0]   wdiff_ff, wdiff_in;

   // Output register, which frees the sequencer while a result waits.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RW-1:0]        out_speed_ff, out_speed_in;
   logic [RW-1:0]        out_accel_ff, out_accel_in;
   logic [RW-1:0]        out_jerk_ff, out_jerk_in;
   logic [TW-1:0]        out_dt_ff, out_dt_in;
   logic                 out_wrapped_ff, out_wrapped_in;
   logic                 out_zero_ff, out_zero_in;
   logic [IW-1:0]        out_index_ff, out_index_in;

   logic                 accept;
   logic                 out_free;
   logic                 dt_zero;
   logic                 wrap_high;
   logic                 wrap_low;
   logic signed [DW-1:0] corr_diff;
   logic signed [DW-1:0] corr_abs;
   logic [DIV_WIDTH-1:0] speed_mag;
   logic signed [RW:0]   wdiff_abs;
   logic signed [RW:0]   accel_wdiff;
   logic signed [RW:0]   speed_wdiff;

   ekest_pkg::div_ctrl_type div_ctrl;
   logic [DIV_WIDTH-1:0]    div_mag;
   logic                    div_done;
   logic [RW-1:0]           div_result;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign dt_zero        = (dt_ff == '0);

   // Counter wrap correction: a jump of a quarter turn or more of the
   // 16-bit counter is taken as a wrap through the opposite end.
   assign wrap_high = diff_ff > ekest_pkg::WRAP_LIMIT;
   assign wrap_low  = diff_ff < ekest_pkg::WRAP_LIMIT_NEG;
   always_comb begin
      if (wrap_high) begin
         corr_diff = diff_ff - ekest_pkg::WRAP_DOWN;
      end else if (wrap_low) begin
         corr_diff = diff_ff + ekest_pkg::WRAP_UP;
      end else begin
         corr_diff = diff_ff;
      end
   end
   assign corr_abs  = corr_diff[DW-1] ? -corr_diff : corr_diff;
   assign speed_mag = DIV_WIDTH'(corr_abs[CW-1:0]) << FRAC_BITS;

   // Differences of saturated results, taken one bit wider so they never
   // overflow, and their magnitude for the divider.
   assign speed_wdiff = $signed({div_result[RW-1], div_result})
                        - $signed({prev_speed_ff[RW-1], prev_speed_ff});
   assign accel_wdiff = $signed({div_result[RW-1], div_result})
                        - $signed({prev_accel_ff[RW-1], prev_accel_ff});
   assign wdiff_abs   = wdiff_ff[RW] ? -wdiff_ff : wdiff_ff;

   always_comb begin
      div_ctrl.start = 1'b0;
      div_ctrl.neg   = 1'b0;
      div_mag        = speed_mag;
      case (state_ff)
         S_WRAP: begin
            div_ctrl.start = !dt_zero;
            div_ctrl.neg   = corr_diff[DW-1];
         end
         S_ABS_A, S_ABS_J: begin
            div_ctrl.start = 1'b1;
            div_ctrl.neg   = wdiff_ff[RW];
            div_mag        = DIV_WIDTH'(unsigned'(wdiff_abs));
         end
         default: begin
            div_ctrl.start = 1'b0;
         end
      endcase
   end

   ekest_div #(
      .DIV_WIDTH (DIV_WIDTH),
      .RES_WIDTH (RW)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (div_ctrl),
      .mag     (div_mag),
      .divisor (dt_ff),
      .done    (div_done),
      .result  (div_result)
   );

   always_comb begin
      state_in       = state_ff;
      prev_count_in  = prev_count_ff;
      prev_time_in   = prev_time_ff;
      prev_speed_in  = prev_speed_ff;
      prev_accel_in  = prev_accel_ff;
      samples_in     = samples_ff;
      diff_in        = diff_ff;
      dt_in          = dt_ff;
      index_in       = index_ff;
      wrapped_in     = wrapped_ff;
      speed_in       = speed_ff;
      accel_in       = accel_ff;
      jerk_in        = jerk_ff;
      wdiff_in       = wdiff_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      out_speed_in   = out_speed_ff;
      out_accel_in   = out_accel_ff;
      out_jerk_in    = out_jerk_ff;
      out_dt_in      = out_dt_ff;
      out_wrapped_in = out_wrapped_ff;
      out_zero_in    = out_zero_ff;
      out_index_in   = out_index_ff;
      case (state_ff)
         S_IDLE: begin
            // Count and time differences are taken at the transfer, so the
            // history can move on at once.
            if (accept) begin
               diff_in       = $signed({req_chan.count_value[CW-1], req_chan.count_value})
                               - $signed({prev_count_ff[CW-1], prev_count_ff});
               dt_in         = req_chan.time_us - prev_time_ff;
               index_in      = samples_ff;
               prev_count_in = req_chan.count_value;
               prev_time_in  = req_chan.time_us;
               samples_in    = samples_ff + 1'b1;
               state_in      = S_WRAP;
            end
         end
         S_WRAP: begin
            wrapped_in = wrap_high || wrap_low;
            if (dt_zero) begin
               // No interval: hold the derivatives and report zero jerk.
               speed_in = prev_speed_ff;
               accel_in = prev_accel_ff;
               jerk_in  = '0;
               state_in = S_OUT;
            end else begin
               state_in = S_DIV_S;
            end
         end
         S_DIV_S: begin
            if (div_done) begin
               speed_in = div_result;
               wdiff_in = speed_wdiff;
               state_in = S_ABS_A;
            end
         end
         S_ABS_A: begin
            state_in = S_DIV_A;
         end
         S_DIV_A: begin
            if (div_done) begin
               accel_in = div_result;
               wdiff_in = accel_wdiff;
               state_in = S_ABS_J;
            end
         end
         S_ABS_J: begin
            state_in = S_DIV_J;
         end
         S_DIV_J: begin
            if (div_done) begin
               jerk_in  = div_result;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               out_speed_in   = speed_ff;
               out_accel_in   = accel_ff;
               out_jerk_in    = jerk_ff;
               out_dt_in      = dt_ff;
               out_wrapped_in = wrapped_ff;
               out_zero_in    = dt_zero;
               out_index_in   = index_ff;
               prev_speed_in  = speed_ff;
               prev_accel_in  = accel_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         prev_count_ff <= '0;
         prev_time_ff  <= '0;
         prev_speed_ff <= '0;
         prev_accel_ff <= '0;
         samples_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         prev_count_ff <= prev_count_in;
         prev_time_ff  <= prev_time_in;
         prev_speed_ff <= prev_speed_in;
         prev_accel_ff <= prev_accel_in;
         samples_ff    <= samples_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      diff_ff        <= diff_in;
      dt_ff          <= dt_in;
      index_ff       <= index_in;
      wrapped_ff     <= wrapped_in;
      speed_ff       <= speed_in;
      accel_ff       <= accel_in;
      jerk_ff        <= jerk_in;
      wdiff_ff       <= wdiff_in;
      out_speed_ff   <= out_speed_in;
      out_accel_ff   <= out_accel_in;
      out_jerk_ff    <= out_jerk_in;
      out_dt_ff      <= out_dt_in;
      out_wrapped_ff <= out_wrapped_in;
      out_zero_ff    <= out_zero_in;
      out_index_ff   <= out_index_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.speed         = out_speed_ff;
   assign rsp_chan.accel         = out_accel_ff;
   assign rsp_chan.jerk          = out_jerk_ff;
   assign rsp_chan.elapsed_us    = out_dt_ff;
   assign rsp_chan.wrapped       = out_wrapped_ff;
   assign rsp_chan.zero_interval = out_zero_ff;
   assign rsp_chan.sample_index  = out_index_ff;

   a_result_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("result valid raised outside the output step");

   a_zero_interval_jerk: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_zero_ff |-> out_jerk_ff == '0)
      else $error("jerk not zero for a zero interval");

   a_transfer_starts_work: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_WRAP && samples_ff == $past(samples_ff) + 1'b1)
      else $error("sample transfer did not start the sequencer");

   a_div_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV_S || state_ff == S_DIV_A || state_ff == S_DIV_J)
      else $error("divider finished while the sequencer was not waiting");

endmodule

>>> tb/encoder_kinematics_estimator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Encoder kinematics estimator testbench
// Feeds counter samples through the request channel and checks every speed,
// acceleration and jerk result against an in-bench predictor or typed-in
// values. A directed table is walked first, followed by randomized motion
// profiles. Both channels see random idle bursts except at the end of the run.
// ----------------------------------------------------------------------------
module encoder_kinematics_estimator_tb;

   localparam int    RES_W         = 48;
   localparam int    Q_BITS        = 24;
   localparam longint Q_ONE        = 64'sd1 << Q_BITS;
   localparam int    RANDOM_ITEMS  = 650;
   localparam int    STEADY_ITEMS  = 80;
   localparam int    PAUSE_AT      = 300;
   localparam int    DRAIN_CYCLES  = 200;
   localparam int    CYCLE_LIMIT   = 1000000;
   localparam int    REPORT_LIMIT  = 10;

   // Counter wrap correction, kept independent of the package values.
   localparam int    WRAP_THRESHOLD = 16383;
   localparam int    WRAP_FALL      = 32767;
   localparam int    WRAP_RISE      = 32768;

   localparam logic [63:0] MAG_HALF = 64'd1 << (RES_W - 1);

   typedef struct packed {
      logic signed [RES_W-1:0] speed;
      logic signed [RES_W-1:0] accel;
      logic signed [RES_W-1:0] jerk;
      logic [31:0]             elapsed_us;
      logic                    wrapped;
      logic                    zero_interval;
      logic [31:0]             sample_index;
   } kin_result_type;

   typedef struct packed {
      logic signed [15:0] count;
      logic [31:0]        stamp;
      logic               golden;
      kin_result_type     want;
   } sample_row_type;

   logic clock;
   logic reset;

   ekest_req_if                     req_chan ();
   ekest_rsp_if #(.RES_WIDTH(RES_W)) rsp_chan ();

   encoder_kinematics_estimator #(
      .FRAC_BITS   (Q_BITS),
      .RESULT_WIDTH(RES_W)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   // Kinematic history as the block should hold it after each accepted sample.
   logic signed [15:0]      hist_count;
   logic [31:0]             hist_time;
   logic signed [RES_W-1:0] hist_speed;
   logic signed [RES_W-1:0] hist_accel;
   logic [31:0]             hist_index;

   // Results still owed by the block, oldest first.
   kin_result_type pending_kinematics[$];
   sample_row_type directed_samples[$];

   int  mismatch_count = 0;
   int  cycle_count    = 0;
   // Set for the closing stretch of the run, where neither side idles.
   bit  steady_run     = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Truncating division of a signed numerator by the elapsed time, clamped
   // to the signed result range.
   function automatic logic signed [RES_W-1:0] clamp_quotient(input longint num,
                                                              input logic [31:0] dt);
      logic        neg;
      logic [63:0] mag;
      logic [63:0] quo;
      neg = num < 0;
      mag = neg ? -num : num;
      quo = mag / {32'd0, dt};
      if (neg) begin
         if (quo > MAG_HALF) quo = MAG_HALF;
         return RES_W'(-quo);
      end
      if (quo > MAG_HALF - 1) quo = MAG_HALF - 1;
      return RES_W'(quo);
   endfunction

   // Works out the result of one sample and advances the history.
   function automatic kin_result_type predict_kinematics(input logic signed [15:0] count,
                                                         input logic [31:0] stamp);
      int             delta;
      logic [31:0]    dt;
      kin_result_type r;
      delta = int'(count) - int'(hist_count);
      dt    = stamp - hist_time;
      r.wrapped = 1'b0;
      if (delta > WRAP_THRESHOLD) begin
         delta     = delta - WRAP_FALL;
         r.wrapped = 1'b1;
      end else if (delta < -WRAP_THRESHOLD) begin
         delta     = delta + WRAP_RISE;
         r.wrapped = 1'b1;
      end
      if (dt == 0) begin
         // No time has passed: derivatives are held and jerk reads zero.
         r.speed = hist_speed;
         r.accel = hist_accel;
         r.jerk  = '0;
      end else begin
         r.speed = clamp_quotient(longint'(delta) * Q_ONE, dt);
         r.accel = clamp_quotient(longint'($signed(r.speed)) - longint'(hist_speed), dt);
         r.jerk  = clamp_quotient(longint'($signed(r.accel)) - longint'(hist_accel), dt);
      end
      r.elapsed_us    = dt;
      r.zero_interval = (dt == 0);
      r.sample_index  = hist_index;
      hist_count = count;
      hist_time  = stamp;
      hist_speed = r.speed;
      hist_accel = r.accel;
      hist_index = hist_index + 1;
      return r;
   endfunction

   task automatic plan_sample(input logic signed [15:0] count, input logic [31:0] stamp);
      sample_row_type row;
      row        = '0;
      row.count  = count;
      row.stamp  = stamp;
      directed_samples.push_back(row);
   endtask

   task automatic plan_known(input logic signed [15:0] count, input logic [31:0] stamp,
                             input longint spd,
                             input longint acc,
                             input longint jrk,
                             input logic [31:0] elapsed, input logic wrap_flag,
                             input logic zero_flag, input logic [31:0] index);
      sample_row_type row;
      row.count              = count;
      row.stamp              = stamp;
      row.golden             = 1'b1;
      row.want.speed         = RES_W'(spd);
      row.want.accel         = RES_W'(acc);
      row.want.jerk          = RES_W'(jrk);
      row.want.elapsed_us    = elapsed;
      row.want.wrapped       = wrap_flag;
      row.want.zero_interval = zero_flag;
      row.want.sample_index  = index;
      directed_samples.push_back(row);
   endtask

   // Presents one sample and returns at the clock edge of its transfer.
   task automatic transfer_sample(input logic signed [15:0] count, input logic [31:0] stamp);
      req_chan.valid       <= 1'b1;
      req_chan.count_value <= count;
      req_chan.time_us     <= stamp;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Random idle burst on the request side after a transfer.
   task automatic sender_gap();
      if (!steady_run && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   // Result side: ready drops in random bursts until the closing stretch.
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!steady_run && $urandom_range(0, 2) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         repeat ($urandom_range(1, 60)) @(posedge clock);
      end
   end

   // Every result transfer is matched against the oldest expectation.
   always @(posedge clock) begin
      kin_result_type got;
      kin_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.speed         = rsp_chan.speed;
         got.accel         = rsp_chan.accel;
         got.jerk          = rsp_chan.jerk;
         got.elapsed_us    = rsp_chan.elapsed_us;
         got.wrapped       = rsp_chan.wrapped;
         got.zero_interval = rsp_chan.zero_interval;
         got.sample_index  = rsp_chan.sample_index;
         if (pending_kinematics.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected result transfer, sample_index %0d", got.sample_index);
         end else begin
            want = pending_kinematics.pop_front();
            if (got.speed !== want.speed || got.accel !== want.accel ||
                got.jerk !== want.jerk || got.elapsed_us !== want.elapsed_us ||
                got.wrapped !== want.wrapped || got.zero_interval !== want.zero_interval ||
                got.sample_index !== want.sample_index) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("mismatch, sample %0d", want.sample_index);
                  $display("   expected: speed %0d accel %0d jerk %0d dt %0d wrap %0b zero %0b",
                           want.speed, want.accel, want.jerk,
                           want.elapsed_us, want.wrapped, want.zero_interval);
                  $display("   got %0d: speed %0d accel %0d jerk %0d dt %0d wrap %0b zero %0b",
                           got.sample_index, got.speed, got.accel, got.jerk,
                           got.elapsed_us, got.wrapped, got.zero_interval);
               end
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin
      logic signed [15:0] count_now;
      logic [31:0]        stamp_now;
      int                 kind;
      kin_result_type     predicted;

      clock                = 1'b0;
      reset               <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.count_value <= '0;
      req_chan.time_us     <= '0;
      hist_count = '0;
      hist_time  = '0;
      hist_speed = '0;
      hist_accel = '0;
      hist_index = '0;

      // Directed table. Rows with typed-in results follow directly from the
      // zero history after reset; the rest are left to the predictor.
      // Zero interval straight out of reset: everything holds at zero.
      plan_known(16'sd0, 32'd0, '0, '0, '0, 32'd0, 1'b0, 1'b1, 32'd0);
      // One count in one microsecond: one Q24 unit in all three derivatives.
      plan_known(16'sd1, 32'd1, Q_ONE, Q_ONE, Q_ONE, 32'd1, 1'b0, 1'b0, 32'd1);
      // Zero interval with history: speed and accel repeat, jerk is zero.
      plan_known(16'sd1, 32'd1, Q_ONE, Q_ONE, '0, 32'd0, 1'b0, 1'b1, 32'd2);
      // Jump to the positive extreme wraps down to a step of minus one.
      plan_known(16'sd32767, 32'd2, -Q_ONE, -2 * Q_ONE, -3 * Q_ONE,
                 32'd1, 1'b1, 1'b0, 32'd3);
      // Positive to negative extreme: the widest downward difference.
      plan_known(-16'sd32768, 32'd3, -32767 * Q_ONE, -32766 * Q_ONE, -32764 * Q_ONE,
                 32'd1, 1'b1, 1'b0, 32'd4);
      plan_sample(16'sd32767, 32'hFFFF_FFFF);
      plan_sample(16'sd32767, 32'h0000_0000);     // timestamp wraps, one microsecond
      plan_sample(16'sd0, 32'd100);
      plan_sample(16'sd16383, 32'd200);            // largest step without correction
      plan_sample(16'sd0, 32'd300);
      plan_sample(16'sd16384, 32'd400);            // smallest step that is corrected
      plan_sample(16'sd0, 32'd500);
      plan_sample(-16'sd1, 32'd500);
      plan_sample(-16'sd21846, 32'h5555_5555);
      plan_sample(16'sd21845, 32'hAAAA_AAAA);
      plan_sample(-16'sd1, 32'hFFFF_FFFE);
      plan_sample(16'sd0, 32'h7FFF_FFFF);
      plan_sample(16'sd100, 32'h8000_0000);
      plan_sample(16'sd100, 32'h8000_03E8);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_samples[i]) begin
         transfer_sample(directed_samples[i].count, directed_samples[i].stamp);
         predicted = predict_kinematics(directed_samples[i].count, directed_samples[i].stamp);
         pending_kinematics.push_back(directed_samples[i].golden ?
                                      directed_samples[i].want : predicted);
         sender_gap();
      end

      // Random part: mostly smooth motion, with stalls in time, steps near
      // the wrap threshold, very short intervals and raw random samples.
      count_now = hist_count;
      stamp_now = hist_time;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - STEADY_ITEMS) steady_run = 1'b1;
         if (n == PAUSE_AT) begin
            // Let the block drain completely before the next transfer.
            req_chan.valid <= 1'b0;
            do @(posedge clock); while (pending_kinematics.size() != 0);
         end
         kind = $urandom_range(0, 99);
         if (kind < 60) begin
            count_now = count_now + 16'($urandom_range(0, 4000) - 2000);
            stamp_now = stamp_now + $urandom_range(1, 2000);
         end else if (kind < 70) begin
            count_now = count_now + 16'($urandom_range(0, 200) - 100);
         end else if (kind < 80) begin
            if ($urandom_range(0, 1) == 1)
               count_now = count_now + 16'($urandom_range(16000, 16800));
            else
               count_now = count_now - 16'($urandom_range(16000, 16800));
            stamp_now = stamp_now + $urandom_range(1, 50);
         end else if (kind < 88) begin
            count_now = 16'($urandom);
            stamp_now = $urandom;
         end else begin
            count_now = count_now + 16'($urandom_range(0, 20000) - 10000);
            stamp_now = stamp_now + $urandom_range(1, 3);
         end
         transfer_sample(count_now, stamp_now);
         pending_kinematics.push_back(predict_kinematics(count_now, stamp_now));
         sender_gap();
      end

      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_kinematics.size() != 0);
      // Stray results after the last expected one still get caught here.
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
